[hw/rtl/assert_macros.svh]
// assertion helpers used by the rtl
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// property that must hold at every rising clock edge outside reset
`define ASSERT_PROP(lbl, clk, rst_n, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);

// expression that must never be true outside reset
`define ASSERT_NEVER(lbl, clk, rst_n, expr, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) !(expr)) else $error(msg);

`endif

[hw/rtl/alc_pkg.sv]
`default_nettype none

package alc_pkg;

  // field widths
  localparam int CNT_W    = 16;
  localparam int CODE_W   = 3;
  localparam int GT_W     = 2 * CODE_W;
  localparam int LUX_W    = 26;
  localparam int REGION_W = 3;

  // ratio compare: 100 * ch1 against k * (ch0 + ch1)
  localparam int RATIO_W = CNT_W + 8;
  localparam logic [RATIO_W-1:0] RATIO_SCALE = RATIO_W'(100);
  localparam logic [RATIO_W-1:0] RATIO_LOW   = RATIO_W'(45);
  localparam logic [RATIO_W-1:0] RATIO_MID   = RATIO_W'(64);
  localparam logic [RATIO_W-1:0] RATIO_HIGH  = RATIO_W'(85);

  // region codes
  localparam logic [REGION_W-1:0] REGION_INVALID = 3'd0;
  localparam logic [REGION_W-1:0] REGION_LOW     = 3'd1;
  localparam logic [REGION_W-1:0] REGION_MID     = 3'd2;
  localparam logic [REGION_W-1:0] REGION_HIGH    = 3'd3;
  localparam logic [REGION_W-1:0] REGION_OUT     = 3'd4;

  localparam logic [LUX_W-1:0] LUX_MAX = {LUX_W{1'b1}};

endpackage

`default_nettype wire

[hw/rtl/alc_front.sv]
`default_nettype none

// stages 1-3: region classify, coefficient multiply, combine and scale
module alc_front #(
  parameter int COEF_FRAC_BITS = 12,
  parameter int Q_W            = 28
) (
  input  wire logic                         clk_i,
  input  wire logic                         rst_ni,
  input  wire logic                         en_i,
  input  wire logic                         valid_i,
  input  wire logic [alc_pkg::CNT_W-1:0]    ch0_count_i,
  input  wire logic [alc_pkg::CNT_W-1:0]    ch1_count_i,
  input  wire logic [alc_pkg::CODE_W-1:0]   gain_code_i,
  input  wire logic [alc_pkg::CODE_W-1:0]   int_code_i,
  output logic                              valid_o,
  output logic [Q_W-1:0]                    quot_num_o,
  output logic [alc_pkg::GT_W-1:0]          divisor_o,
  output logic [alc_pkg::REGION_W-1:0]      region_o
);
  import alc_pkg::*;

  localparam int COEF_W = COEF_FRAC_BITS + 3;
  localparam int PROD_W = COEF_W + CNT_W;
  localparam int SUM_W  = PROD_W + 1;
  localparam int SHIFT  = COEF_FRAC_BITS - 8;

  // coefficients rounded half up into the fraction format
  localparam longint unsigned SCALE = 64'd1 << COEF_FRAC_BITS;
  localparam logic [COEF_W-1:0] K_LOW_A  = COEF_W'((64'd17743 * SCALE + 64'd5000) / 64'd10000);
  localparam logic [COEF_W-1:0] K_LOW_B  = COEF_W'((64'd11059 * SCALE + 64'd5000) / 64'd10000);
  localparam logic [COEF_W-1:0] K_MID_A  = COEF_W'((64'd42785 * SCALE + 64'd5000) / 64'd10000);
  localparam logic [COEF_W-1:0] K_MID_B  = COEF_W'((64'd19548 * SCALE + 64'd5000) / 64'd10000);
  localparam logic [COEF_W-1:0] K_HIGH_A = COEF_W'((64'd5926 * SCALE + 64'd5000) / 64'd10000);
  localparam logic [COEF_W-1:0] K_HIGH_B = COEF_W'((64'd1185 * SCALE + 64'd5000) / 64'd10000);

  // stage 1 signals
  logic [CNT_W:0]        sum_cnt;
  logic [RATIO_W-1:0]    b_scaled, s_low, s_mid, s_high;
  logic                  invalid;
  logic [REGION_W-1:0]   region_d;
  logic [GT_W-1:0]       gt_d;
  logic                  s1_valid_q;
  logic [CNT_W-1:0]      s1_a_q, s1_b_q;
  logic [GT_W-1:0]       s1_gt_q;
  logic [REGION_W-1:0]   s1_region_q;

  // stage 2 signals
  logic [COEF_W-1:0]     k0, k1;
  logic                  k1_neg;
  logic [PROD_W-1:0]     p0_d, p1_d;
  logic                  s2_valid_q;
  logic [PROD_W-1:0]     s2_p0_q, s2_p1_q;
  logic                  s2_neg_q;
  logic [GT_W-1:0]       s2_gt_q;
  logic [REGION_W-1:0]   s2_region_q;

  // stage 3 signals
  logic [SUM_W-1:0]      sum_d;
  logic                  s3_valid_q;
  logic [Q_W-1:0]        s3_q_q;
  logic [GT_W-1:0]       s3_gt_q;
  logic [REGION_W-1:0]   s3_region_q;

  // region classify by cross-multiplication
  always_comb begin
    sum_cnt  = {1'b0, ch0_count_i} + {1'b0, ch1_count_i};
    b_scaled = RATIO_W'(ch1_count_i) * RATIO_SCALE;
    s_low    = RATIO_W'(sum_cnt) * RATIO_LOW;
    s_mid    = RATIO_W'(sum_cnt) * RATIO_MID;
    s_high   = RATIO_W'(sum_cnt) * RATIO_HIGH;
    invalid  = (gain_code_i == '0) || (int_code_i == '0) || (sum_cnt == '0);
    if (invalid) begin
      region_d = REGION_INVALID;
    end else if (b_scaled < s_low) begin
      region_d = REGION_LOW;
    end else if (b_scaled < s_mid) begin
      region_d = REGION_MID;
    end else if (b_scaled < s_high) begin
      region_d = REGION_HIGH;
    end else begin
      region_d = REGION_OUT;
    end
    // divisor is forced to one for invalid beats so the divider stays sane
    gt_d = invalid ? GT_W'(1) : GT_W'(gain_code_i) * GT_W'(int_code_i);
  end

  // coefficient select and multiply
  always_comb begin
    case (s1_region_q)
      REGION_LOW: begin
        k0 = K_LOW_A;  k1 = K_LOW_B;  k1_neg = 1'b0;
      end
      REGION_MID: begin
        k0 = K_MID_A;  k1 = K_MID_B;  k1_neg = 1'b1;
      end
      REGION_HIGH: begin
        k0 = K_HIGH_A; k1 = K_HIGH_B; k1_neg = 1'b0;
      end
      default: begin
        k0 = '0;       k1 = '0;       k1_neg = 1'b0;
      end
    endcase
    p0_d = PROD_W'(k0) * PROD_W'(s1_a_q);
    p1_d = PROD_W'(k1) * PROD_W'(s1_b_q);
  end

  // combine products, clamp negative at zero
  always_comb begin
    if (s2_neg_q) begin
      sum_d = (s2_p0_q >= s2_p1_q) ? SUM_W'(s2_p0_q - s2_p1_q) : '0;
    end else begin
      sum_d = SUM_W'(s2_p0_q) + SUM_W'(s2_p1_q);
    end
  end

  // valid bits
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_valid_q <= 1'b0;
      s2_valid_q <= 1'b0;
      s3_valid_q <= 1'b0;
    end else if (en_i) begin
      s1_valid_q <= valid_i;
      s2_valid_q <= s1_valid_q;
      s3_valid_q <= s2_valid_q;
    end
  end

  // payload registers
  always_ff @(posedge clk_i) begin
    if (en_i) begin
      s1_a_q      <= ch0_count_i;
      s1_b_q      <= ch1_count_i;
      s1_gt_q     <= gt_d;
      s1_region_q <= region_d;
      s2_p0_q     <= p0_d;
      s2_p1_q     <= p1_d;
      s2_neg_q    <= k1_neg;
      s2_gt_q     <= s1_gt_q;
      s2_region_q <= s1_region_q;
      s3_q_q      <= sum_d[SUM_W-1:SHIFT];
      s3_gt_q     <= s2_gt_q;
      s3_region_q <= s2_region_q;
    end
  end

  assign valid_o    = s3_valid_q;
  assign quot_num_o = s3_q_q;
  assign divisor_o  = s3_gt_q;
  assign region_o   = s3_region_q;

endmodule

`default_nettype wire

[hw/rtl/alc_div.sv]
`default_nettype none

// pipelined restoring divider, BPS quotient bits per stage
module alc_div #(
  parameter int NUM_W = 28,
  parameter int BPS   = 4
) (
  input  wire logic                          clk_i,
  input  wire logic                          rst_ni,
  input  wire logic                          en_i,
  input  wire logic                          valid_i,
  input  wire logic [NUM_W-1:0]              num_i,
  input  wire logic [alc_pkg::GT_W-1:0]      divisor_i,
  input  wire logic [alc_pkg::REGION_W-1:0]  region_i,
  output logic                               valid_o,
  output logic [NUM_W-1:0]                   quot_o,
  output logic [alc_pkg::REGION_W-1:0]       region_o
);
  import alc_pkg::*;

  localparam int STAGES = (NUM_W + BPS - 1) / BPS;
  localparam int PAD_W  = STAGES * BPS;

  logic                vld_q    [STAGES];
  logic [PAD_W-1:0]    num_q    [STAGES];
  logic [PAD_W-1:0]    quo_q    [STAGES];
  logic [GT_W-1:0]     rem_q    [STAGES];
  logic [GT_W-1:0]     div_q    [STAGES];
  logic [REGION_W-1:0] region_q [STAGES];

  for (genvar s = 0; s < STAGES; s++) begin : g_stage
    logic                vld_in;
    logic [PAD_W-1:0]    num_in, quo_in, num_d, quo_d;
    logic [GT_W-1:0]     rem_in, div_in, rem_d;
    logic [REGION_W-1:0] region_in;

    // stage inputs
    if (s == 0) begin : g_first
      assign vld_in    = valid_i;
      assign num_in    = PAD_W'(num_i);
      assign quo_in    = '0;
      assign rem_in    = '0;
      assign div_in    = divisor_i;
      assign region_in = region_i;
    end else begin : g_next
      assign vld_in    = vld_q[s-1];
      assign num_in    = num_q[s-1];
      assign quo_in    = quo_q[s-1];
      assign rem_in    = rem_q[s-1];
      assign div_in    = div_q[s-1];
      assign region_in = region_q[s-1];
    end

    // shift-subtract steps
    always_comb begin
      logic [GT_W:0] trial;
      rem_d = rem_in;
      num_d = num_in;
      quo_d = quo_in;
      for (int j = 0; j < BPS; j++) begin
        trial = {rem_d, num_d[PAD_W-1]};
        num_d = {num_d[PAD_W-2:0], 1'b0};
        if (trial >= {1'b0, div_in}) begin
          rem_d = GT_W'(trial - {1'b0, div_in});
          quo_d = {quo_d[PAD_W-2:0], 1'b1};
        end else begin
          rem_d = trial[GT_W-1:0];
          quo_d = {quo_d[PAD_W-2:0], 1'b0};
        end
      end
    end

    // stage valid bit
    always_ff @(posedge clk_i or negedge rst_ni) begin
      if (!rst_ni) begin
        vld_q[s] <= 1'b0;
      end else if (en_i) begin
        vld_q[s] <= vld_in;
      end
    end

    // stage payload
    always_ff @(posedge clk_i) begin
      if (en_i) begin
        num_q[s]    <= num_d;
        quo_q[s]    <= quo_d;
        rem_q[s]    <= rem_d;
        div_q[s]    <= div_in;
        region_q[s] <= region_in;
      end
    end
  end

  assign valid_o  = vld_q[STAGES-1];
  assign quot_o   = quo_q[STAGES-1][NUM_W-1:0];
  assign region_o = region_q[STAGES-1];

endmodule

`default_nettype wire

[hw/rtl/ambient_light_lux_calc.sv]
`default_nettype none

// channel  direction  handshake               payload
// in       input      in_valid_i / in_stall_o   ch0_count_i, ch1_count_i, gain_code_i, int_code_i
// out      output     out_valid_o / out_stall_i lux_q8_o, region_o
//
// one beat accepted per cycle unless the output beat is stalled; each beat passes
// through 3 front stages, 7 divider stages of 4 quotient bits and 1 output register
// the divider holds most of the stages; throughput is one beat per clock while not stalled
// a stalled output beat freezes the whole pipeline; in_stall_o follows it
// reset clears the valid bits only, no clearing pass
module ambient_light_lux_calc #(
  parameter int COEF_FRAC_BITS = 12
) (
  input  wire logic                         clk_i,
  input  wire logic                         rst_ni,
  input  wire logic                         in_valid_i,
  output logic                              in_stall_o,
  input  wire logic [alc_pkg::CNT_W-1:0]    ch0_count_i,
  input  wire logic [alc_pkg::CNT_W-1:0]    ch1_count_i,
  input  wire logic [alc_pkg::CODE_W-1:0]   gain_code_i,
  input  wire logic [alc_pkg::CODE_W-1:0]   int_code_i,
  output logic                              out_valid_o,
  input  wire logic                         out_stall_i,
  output logic [alc_pkg::LUX_W-1:0]         lux_q8_o,
  output logic [alc_pkg::REGION_W-1:0]      region_o
);
  import alc_pkg::*;

  `include "assert_macros.svh"

  localparam int COEF_W = COEF_FRAC_BITS + 3;
  localparam int SUM_W  = COEF_W + CNT_W + 1;
  localparam int Q_W    = SUM_W - (COEF_FRAC_BITS - 8);

  logic                en;
  logic                fr_valid;
  logic [Q_W-1:0]      fr_num;
  logic [GT_W-1:0]     fr_div;
  logic [REGION_W-1:0] fr_region;
  logic                dv_valid;
  logic [Q_W-1:0]      dv_quot;
  logic [REGION_W-1:0] dv_region;
  logic [LUX_W-1:0]    lux_d;
  logic                out_valid_q;
  logic [LUX_W-1:0]    lux_q;
  logic [REGION_W-1:0] region_q;

  // pipeline advances unless the output beat is held
  assign en         = !(out_valid_q && out_stall_i);
  assign in_stall_o = !en;

  alc_front #(
    .COEF_FRAC_BITS (COEF_FRAC_BITS),
    .Q_W            (Q_W)
  ) u_front (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .en_i        (en),
    .valid_i     (in_valid_i),
    .ch0_count_i (ch0_count_i),
    .ch1_count_i (ch1_count_i),
    .gain_code_i (gain_code_i),
    .int_code_i  (int_code_i),
    .valid_o     (fr_valid),
    .quot_num_o  (fr_num),
    .divisor_o   (fr_div),
    .region_o    (fr_region)
  );

  alc_div #(
    .NUM_W (Q_W),
    .BPS   (4)
  ) u_div (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .en_i      (en),
    .valid_i   (fr_valid),
    .num_i     (fr_num),
    .divisor_i (fr_div),
    .region_i  (fr_region),
    .valid_o   (dv_valid),
    .quot_o    (dv_quot),
    .region_o  (dv_region)
  );

  // saturate quotient to the output range
  always_comb begin
    if (dv_quot > Q_W'(LUX_MAX)) begin
      lux_d = LUX_MAX;
    end else begin
      lux_d = dv_quot[LUX_W-1:0];
    end
  end

  // output register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (en) begin
      out_valid_q <= dv_valid;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en) begin
      lux_q    <= lux_d;
      region_q <= dv_region;
    end
  end

  assign out_valid_o = out_valid_q;
  assign lux_q8_o    = lux_q;
  assign region_o    = region_q;

  // checks
  `ASSERT_PROP(a_zero_lux_outside, clk_i, rst_ni, out_valid_o && (region_o == REGION_INVALID || region_o == REGION_OUT) |-> lux_q8_o == '0, "nonzero lux for invalid or out of range beat")
  `ASSERT_NEVER(a_bad_region, clk_i, rst_ni, out_valid_o && region_o > REGION_OUT, "region code out of range")
  `ASSERT_PROP(a_out_from_div, clk_i, rst_ni, $rose(out_valid_o) |-> $past(dv_valid), "output beat without divider beat")

endmodule

`default_nettype wire
